[sv/lfpd_pkg.sv]
package lfpd_pkg;

	// gain fraction bits (q8.8)
	localparam int unsigned GAIN_FRAC_BITS = 8;

	// zero bearing in hundredths of a degree
	localparam logic [16:0] BEARING_ZERO_CDEG = 17'd9000;

	// reset value of the following distance
	localparam logic [15:0] FOLLOW_RESET_MM = 16'd750;

	// width of the accumulator that holds p term plus d quotient
	localparam int unsigned ACC_W = 36;

	// divider steps, one quotient bit each
	localparam logic [4:0] DIV_LAST_STEP = 5'd31;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_DIST_KP   = 3'd0,
		REG_DIST_KD   = 3'd1,
		REG_ANG_KP    = 3'd2,
		REG_ANG_KD    = 3'd3,
		REG_FOLLOW_MM = 3'd4
	} cfg_reg_t;

	// sequencer states, one-hot
	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_MULP = 7'b0000010,
		ST_MULD = 7'b0000100,
		ST_DIV  = 7'b0001000,
		ST_ADD  = 7'b0010000,
		ST_FIN  = 7'b0100000,
		ST_OUT  = 7'b1000000
	} seq_state_t;

	// clamp the accumulator to signed 32 bits
	function automatic logic [31:0] sat32(input logic signed [ACC_W-1:0] x);
		logic signed [ACC_W-1:0] hi;
		logic signed [ACC_W-1:0] lo;
		logic [31:0] r;
		hi = ACC_W'(signed'(33'sh0_7FFF_FFFF));
		lo = ACC_W'(signed'(33'sh1_8000_0000));
		if (x > hi) begin
			r = 32'h7FFF_FFFF;
		end else if (x < lo) begin
			r = 32'h8000_0000;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

endpackage

[sv/leader_follow_pd_controller.sv]
// channel  | handshake                  | payload
// ---------+----------------------------+---------------------------------------------
// in       | in_valid / in_ready        | leader_seen, leader_distance_mm,
//          |                            | start_bearing_cdeg, end_bearing_cdeg, time_ms
// out      | out_valid / out_ready      | linear_cmd, angular_cmd, derivative_used
// cfg      | cfg_we, cfg_index          | cfg_wdata (16 bit)
//
// a found item runs two pd loops one after the other on one shared 16x18 multiplier and
// one 32-step restoring divider; a loop skips the divider when the time gap is zero,
// and an item without the leader goes straight to the output stage.
// in_ready is high only while the sequencer is idle; a finished result waits in the
// output register while the block goes back to idle and takes the next item.
// arst_n clears the gains, the following distance (to 750 mm) and the loop history.
module leader_follow_pd_controller import lfpd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_wdata,
	// observation items
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        leader_seen,
	input  logic [15:0] leader_distance_mm,
	input  logic [15:0] start_bearing_cdeg,
	input  logic [15:0] end_bearing_cdeg,
	input  logic [31:0] time_ms,
	// command items
	output logic        out_valid,
	input  logic        out_ready,
	output logic signed [31:0] linear_cmd,
	output logic signed [31:0] angular_cmd,
	output logic        derivative_used
);

	// configuration registers
	logic signed [15:0] dist_kp_q, dist_kd_q, ang_kp_q, ang_kd_q;
	logic [15:0] follow_mm_q;

	// loop history
	logic signed [16:0] last_derr_q;
	logic signed [15:0] last_berr_q;
	logic [31:0] last_time_q;
	logic        time_seen_q;

	// sequencer
	seq_state_t state_q;
	logic       loop_q;      // 0: distance loop, 1: bearing loop
	logic       out_valid_q;

	// per-item working registers
	logic signed [16:0] derr_q;
	logic signed [15:0] berr_q;
	logic signed [17:0] ddelta_q;
	logic signed [16:0] bdelta_q;
	logic [31:0] dt_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [31:0] num_q;      // dividend, shifts out while quotient shifts in
	logic [31:0] rem_q;
	logic        neg_q;
	logic [4:0]  cnt_q;
	logic [31:0] lin_q, ang_q;
	logic        du_q;

	// output registers
	logic [31:0] lin_out_q, ang_out_q;
	logic        du_out_q;

	logic accept;
	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	// error terms of the incoming observation
	logic signed [16:0] derr_in;
	logic [16:0]        bsum;
	logic signed [16:0] bdiff;
	logic signed [15:0] berr_in;
	logic signed [17:0] ddelta_in;
	logic signed [16:0] bdelta_in;
	logic [31:0]        dt_in;

	always_comb begin
		derr_in = signed'({1'b0, leader_distance_mm} - {1'b0, follow_mm_q});
		bsum    = {1'b0, start_bearing_cdeg} + {1'b0, end_bearing_cdeg};
		bdiff   = signed'({1'b0, bsum[16:1]} - BEARING_ZERO_CDEG);
		// mean bearing never goes below zero, so only the top can overflow
		if (!bdiff[16] && bdiff[15]) begin
			berr_in = 16'sh7FFF;
		end else begin
			berr_in = bdiff[15:0];
		end
		ddelta_in = 18'(derr_in) - 18'(last_derr_q);
		bdelta_in = 17'(berr_in) - 17'(last_berr_q);
		dt_in     = time_seen_q ? (time_ms - last_time_q) : 32'd0;
	end

	// shared multiplier: p term then d numerator of the current loop
	logic signed [15:0] mul_a;
	logic signed [17:0] mul_b;
	logic signed [33:0] prod;
	logic [33:0]        prod_mag;

	always_comb begin
		if (state_q == ST_MULP) begin
			mul_a = loop_q ? ang_kp_q : dist_kp_q;
			mul_b = loop_q ? 18'(berr_q) : 18'(derr_q);
		end else begin
			mul_a = loop_q ? ang_kd_q : dist_kd_q;
			mul_b = loop_q ? 18'(bdelta_q) : ddelta_q;
		end
		prod     = 34'(mul_a) * 34'(mul_b);
		// |kd * delta| stays below 2^32
		prod_mag = prod[33] ? 34'(-prod) : 34'(prod);
	end

	// restoring divider step
	logic [32:0] rem_sh;
	logic [32:0] rem_sub;
	logic        div_ge;

	always_comb begin
		rem_sh  = {rem_q, num_q[31]};
		rem_sub = rem_sh - {1'b0, dt_q};
		div_ge  = (rem_sh >= {1'b0, dt_q});
	end

	// final scaling, floor by the arithmetic shift
	logic signed [ACC_W-1:0] acc_shift;
	logic [31:0]             acc_sat;
	assign acc_shift = acc_q >>> GAIN_FRAC_BITS;
	assign acc_sat   = sat32(acc_shift);

	logic out_load;
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_ready);

	// control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_kp_q   <= '0;
			dist_kd_q   <= '0;
			ang_kp_q    <= '0;
			ang_kd_q    <= '0;
			follow_mm_q <= FOLLOW_RESET_MM;
			last_derr_q <= '0;
			last_berr_q <= '0;
			last_time_q <= '0;
			time_seen_q <= 1'b0;
			state_q     <= ST_IDLE;
			loop_q      <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_DIST_KP:   dist_kp_q   <= cfg_wdata;
					REG_DIST_KD:   dist_kd_q   <= cfg_wdata;
					REG_ANG_KP:    ang_kp_q    <= cfg_wdata;
					REG_ANG_KD:    ang_kd_q    <= cfg_wdata;
					REG_FOLLOW_MM: follow_mm_q <= cfg_wdata;
					default: ;
				endcase
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						loop_q <= 1'b0;
						if (leader_seen) begin
							// history moves on at once; deltas are already captured
							last_derr_q <= derr_in;
							last_berr_q <= berr_in;
							last_time_q <= time_ms;
							time_seen_q <= 1'b1;
							state_q     <= ST_MULP;
						end else begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_MULP: state_q <= ST_MULD;
				ST_MULD: begin
					cnt_q   <= '0;
					state_q <= (dt_q != 32'd0) ? ST_DIV : ST_FIN;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == DIV_LAST_STEP) begin
						state_q <= ST_ADD;
					end
				end
				ST_ADD: state_q <= ST_FIN;
				ST_FIN: begin
					if (!loop_q) begin
						loop_q  <= 1'b1;
						state_q <= ST_MULP;
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					derr_q   <= derr_in;
					berr_q   <= berr_in;
					ddelta_q <= ddelta_in;
					bdelta_q <= bdelta_in;
					dt_q     <= dt_in;
					lin_q    <= '0;
					ang_q    <= '0;
					du_q     <= leader_seen && (dt_in != 32'd0);
				end
			end
			ST_MULP: acc_q <= ACC_W'(prod);
			ST_MULD: begin
				neg_q <= prod[33];
				num_q <= prod_mag[31:0];
				rem_q <= '0;
			end
			ST_DIV: begin
				rem_q <= div_ge ? rem_sub[31:0] : rem_sh[31:0];
				num_q <= {num_q[30:0], div_ge};
			end
			ST_ADD: begin
				// quotient truncates toward zero, sign applied after
				if (neg_q) begin
					acc_q <= acc_q - signed'(ACC_W'(num_q));
				end else begin
					acc_q <= acc_q + signed'(ACC_W'(num_q));
				end
			end
			ST_FIN: begin
				if (!loop_q) begin
					lin_q <= acc_sat;
				end else begin
					ang_q <= acc_sat;
				end
			end
			ST_OUT: begin
				if (out_load) begin
					lin_out_q <= lin_q;
					ang_out_q <= ang_q;
					du_out_q  <= du_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid       = out_valid_q;
	assign linear_cmd      = lin_out_q;
	assign angular_cmd     = ang_out_q;
	assign derivative_used = du_out_q;

endmodule
